@@ rtl/hcsc_pkg.sv @@
// ----------------------------------------------------------------------------
// hcsc_pkg
// Shared widths, reset values, CORDIC constants and result types for the
// heading change steering controller.
// ----------------------------------------------------------------------------
package hcsc_pkg;

  localparam int ANGLE_FRAC_BITS = 16;
  localparam int ANG_W           = 24;
  localparam int CORDIC_STEPS    = 30;
  localparam int STEP_W          = $clog2(CORDIC_STEPS);
  localparam int XY_W            = 34;
  localparam int Z_W             = 40;
  localparam int MAG_W           = 17;

  localparam logic [15:0] RST_SPEED = 16'd384;
  localparam logic [15:0] RST_GAIN  = 16'd512;
  localparam logic [15:0] RST_AXLE  = 16'd435;
  localparam logic [16:0] RST_LIMIT = 17'd28595;
  localparam logic [16:0] RST_FLOOR = 17'd1144;
  localparam logic [15:0] RST_BAND  = 16'd572;

  localparam logic OP_REQUEST = 1'b0;
  localparam logic OP_TICK    = 1'b1;

  typedef enum logic [2:0] {
    REG_SPEED = 3'd0, REG_GAIN = 3'd1, REG_AXLE = 3'd2,
    REG_LIMIT = 3'd3, REG_FLOOR = 3'd4, REG_BAND = 3'd5
  } reg_idx_e;

  localparam logic signed [Z_W-1:0] PI_Q30      = 40'sd3373259426;
  localparam logic signed [Z_W-1:0] HALF_PI_Q30 = 40'sd1686629713;
  localparam logic signed [XY_W-1:0] X_INIT     = 34'sd1073741824;

  typedef struct packed {
    logic             y_neg;
    logic [MAG_W-1:0] y_mag;
    logic [MAG_W-1:0] x_q16;
  } cordic_res_t;

  function automatic logic signed [Z_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic signed [Z_W-1:0] v;
    v = '0;
    unique case (idx)
      5'd0:  v = 40'sd843314856;
      5'd1:  v = 40'sd497837829;
      5'd2:  v = 40'sd263043836;
      5'd3:  v = 40'sd133525158;
      5'd4:  v = 40'sd67021686;
      5'd5:  v = 40'sd33543515;
      5'd6:  v = 40'sd16775850;
      5'd7:  v = 40'sd8388437;
      5'd8:  v = 40'sd4194282;
      5'd9:  v = 40'sd2097149;
      5'd10: v = 40'sd1048575;
      5'd11: v = 40'sd524287;
      5'd12: v = 40'sd262143;
      5'd13: v = 40'sd131071;
      5'd14: v = 40'sd65535;
      5'd15: v = 40'sd32767;
      5'd16: v = 40'sd16383;
      5'd17: v = 40'sd8191;
      5'd18: v = 40'sd4095;
      5'd19: v = 40'sd2047;
      5'd20: v = 40'sd1023;
      5'd21: v = 40'sd511;
      5'd22: v = 40'sd255;
      5'd23: v = 40'sd127;
      5'd24: v = 40'sd63;
      5'd25: v = 40'sd31;
      5'd26: v = 40'sd15;
      5'd27: v = 40'sd8;
      5'd28: v = 40'sd4;
      5'd29: v = 40'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/hcsc_cordic.sv @@
// ----------------------------------------------------------------------------
// hcsc_cordic
// Range reduction modulo pi by repeated subtraction, then a rotation-mode
// CORDIC with one micro-rotation per cycle. Returns sin and cos in Q16.
// ----------------------------------------------------------------------------
module hcsc_cordic #(
  parameter int ANGLE_FRAC_BITS = hcsc_pkg::ANGLE_FRAC_BITS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [hcsc_pkg::MAG_W-1:0]    mag_i,
  output logic                          done_o,
  output hcsc_pkg::cordic_res_t         res_o
);

  localparam int A_SH = 30 - ANGLE_FRAC_BITS;

  typedef enum logic [1:0] {S_IDLE, S_REDUCE, S_ROTATE} state_e;

  state_e                               state_q;
  logic signed [hcsc_pkg::XY_W-1:0]     x_q, y_q, x_d, y_d, dx, dy, x16, y16;
  logic signed [hcsc_pkg::Z_W-1:0]      z_q, z_d, at;
  logic [hcsc_pkg::STEP_W-1:0]          it_q;
  logic                                 done_q;
  hcsc_pkg::cordic_res_t                res_q;
  logic [hcsc_pkg::XY_W-1:0]            y_abs;

  always_comb begin
    dx = y_q >>> it_q;
    dy = x_q >>> it_q;
    at = hcsc_pkg::atan_q30(it_q);
    if (!z_q[hcsc_pkg::Z_W-1]) begin
      x_d = x_q - dx;
      y_d = y_q + dy;
      z_d = z_q - at;
    end else begin
      x_d = x_q + dx;
      y_d = y_q - dy;
      z_d = z_q + at;
    end
    x16   = x_d >>> 14;
    y16   = y_d >>> 14;
    y_abs = y16[hcsc_pkg::XY_W-1] ? hcsc_pkg::XY_W'(-y16) : hcsc_pkg::XY_W'(y16);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      it_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            z_q     <= hcsc_pkg::Z_W'(mag_i) <<< A_SH;
            x_q     <= hcsc_pkg::X_INIT;
            y_q     <= '0;
            it_q    <= '0;
            state_q <= S_REDUCE;
          end
        end
        S_REDUCE: begin
          // fold into [-pi/2, pi/2)
          if (z_q >= hcsc_pkg::HALF_PI_Q30) begin
            z_q <= z_q - hcsc_pkg::PI_Q30;
          end else begin
            state_q <= S_ROTATE;
          end
        end
        S_ROTATE: begin
          x_q  <= x_d;
          y_q  <= y_d;
          z_q  <= z_d;
          it_q <= it_q + 1'b1;
          if (it_q == hcsc_pkg::STEP_W'(hcsc_pkg::CORDIC_STEPS - 1)) begin
            res_q.y_neg <= y16[hcsc_pkg::XY_W-1];
            res_q.y_mag <= y_abs[hcsc_pkg::MAG_W-1:0];
            // cos near a right angle: hold at least one
            res_q.x_q16 <= (x16 < 1) ? hcsc_pkg::MAG_W'(1) : x16[hcsc_pkg::MAG_W-1:0];
            done_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

@@ rtl/hcsc_div.sv @@
// ----------------------------------------------------------------------------
// hcsc_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hcsc_div #(
  parameter int NUM_W = 53,
  parameter int DEN_W = 33
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quo_o
);

  localparam int CW = $clog2(NUM_W + 1);

  logic             busy_q, done_q, ge;
  logic [CW-1:0]    cnt_q;
  logic [NUM_W-1:0] acc_q;
  logic [DEN_W-1:0] rem_q, den_q, rem_d;
  logic [DEN_W:0]   trial, diff;

  always_comb begin
    trial = {rem_q, acc_q[NUM_W-1]};
    diff  = trial - {1'b0, den_q};
    ge    = trial >= {1'b0, den_q};
    rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (!busy_q) begin
        if (start_i) begin
          acc_q  <= num_i;
          den_q  <= den_i;
          rem_q  <= '0;
          cnt_q  <= CW'(NUM_W);
          busy_q <= 1'b1;
        end
      end else begin
        acc_q <= {acc_q[NUM_W-2:0], ge};
        rem_q <= rem_d;
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = acc_q;

endmodule

@@ rtl/heading_change_steering_controller.sv @@
// A request gives no word; a tick with zero time gives none.
// A tick in band or with no yaw estimate passes ST_MUL and ST_CMD, and its word is loaded in ST_UPD.
// With a yaw estimate it also passes range reduction, 30 CORDIC steps, ST_MUL1, ST_MUL2
// and NUM_W divider steps (53 at 16 fraction bits) before ST_UPD.
// One item in flight; the bit-serial divider sets the tick rate.
// Reset clears heading, turn flag and registers to their defaults; no clearing pass.
// ----------------------------------------------------------------------------
// heading_change_steering_controller
// Proportional steering with a kinematic bicycle yaw estimate, built from a
// sequencer, a serial CORDIC and a bit-serial divider.
// ----------------------------------------------------------------------------
module heading_change_steering_controller #(
  parameter int ANGLE_FRAC_BITS = hcsc_pkg::ANGLE_FRAC_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        operation_i,
  input  logic signed [23:0] heading_delta_i,
  input  logic [19:0] elapsed_time_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic signed [23:0] steering_angle_o,
  output logic signed [15:0] speed_out_o,
  output logic        turning_o,
  output logic signed [23:0] heading_left_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int NUM_SHIFT = (ANGLE_FRAC_BITS > 16) ? ANGLE_FRAC_BITS - 16 : 0;
  localparam int DEN_SHIFT = (ANGLE_FRAC_BITS < 16) ? 16 - ANGLE_FRAC_BITS : 0;
  localparam int NUM_W     = 53 + NUM_SHIFT;
  localparam int DEN_W     = 33 + DEN_SHIFT;
  localparam int ANG_W     = hcsc_pkg::ANG_W;
  localparam logic signed [ANG_W-1:0] ANG_MAX = 24'sh7FFFFF;
  localparam logic signed [ANG_W-1:0] ANG_MIN = 24'sh800000;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL, ST_CMD, ST_CORD, ST_MUL1, ST_MUL2, ST_DIV, ST_UPD
  } state_e;

  state_e state_q;

  logic [15:0] speed_q, gain_q, axle_q, band_q;
  logic [16:0] limit_q, floor_q;
  logic signed [ANG_W-1:0] rem_q, cmd_q, yaw_q;
  logic        turn_q;
  logic [19:0] dt_q;
  logic signed [39:0] p_q;
  logic [32:0] ys_q;
  logic [DEN_W-1:0] den_q;
  logic [NUM_W-1:0] num_q;
  logic        neg_q, cord_start_q, div_start_q;

  logic        out_valid_q, out_turn_q;
  logic signed [ANG_W-1:0] out_steer_q, out_head_q;
  logic signed [15:0] out_speed_q;

  // cfg decode
  logic               cfg_wr;
  hcsc_pkg::reg_idx_e cfg_idx;

  // datapath
  logic signed [ANG_W:0]   req_sum;
  logic signed [ANG_W-1:0] req_sat;
  logic [ANG_W-1:0] rem_abs, req_abs, yaw_abs, rem_abs_u;
  logic        in_band;
  logic [39:0] p_mag;
  logic [30:0] c_mag, c1, c2, lim_w, flr_w;
  logic signed [ANG_W-1:0] cmd_calc, yaw_sat, rem_new;
  logic [15:0] spd_abs;
  logic [32:0] den_raw;
  logic [52:0] num_raw;
  logic        yaw_go;
  logic [ANG_W-1:0] steer_mag;
  logic [ANG_W-1:0] cmd_abs;

  logic                  cord_done;
  hcsc_pkg::cordic_res_t cord_res;
  hcsc_pkg::cordic_res_t cres_q;
  logic                  div_done;
  logic [NUM_W-1:0]      quo;

  function automatic logic [ANG_W-1:0] abs_ang(input logic signed [ANG_W-1:0] v);
    return v[ANG_W-1] ? ANG_W'(-v) : ANG_W'(v);
  endfunction

  assign cfg_wr  = psel & penable & pwrite & pready;
  assign cfg_idx = hcsc_pkg::reg_idx_e'(paddr[4:2]);
  assign pready  = 1'b1;

  always_comb begin
    prdata = '0;
    unique case (paddr[4:2])
      hcsc_pkg::REG_SPEED: prdata = {16'b0, speed_q};
      hcsc_pkg::REG_GAIN:  prdata = {16'b0, gain_q};
      hcsc_pkg::REG_AXLE:  prdata = {16'b0, axle_q};
      hcsc_pkg::REG_LIMIT: prdata = {15'b0, limit_q};
      hcsc_pkg::REG_FLOOR: prdata = {15'b0, floor_q};
      hcsc_pkg::REG_BAND:  prdata = {16'b0, band_q};
      default:             prdata = '0;
    endcase
  end

  always_comb begin
    req_sum = (ANG_W+1)'(rem_q) + (ANG_W+1)'(heading_delta_i);
    if (req_sum > (ANG_W+1)'(ANG_MAX)) begin
      req_sat = ANG_MAX;
    end else if (req_sum < (ANG_W+1)'(ANG_MIN)) begin
      req_sat = ANG_MIN;
    end else begin
      req_sat = req_sum[ANG_W-1:0];
    end
    req_abs = abs_ang(req_sat);
    rem_abs = abs_ang(rem_q);
    in_band = rem_abs <= {8'b0, band_q};

    // command: gain * error / 256 toward zero, clamp, raise to floor, clamp
    p_mag = p_q[39] ? 40'(-p_q) : 40'(p_q);
    c_mag = p_mag[38:8];
    lim_w = {14'b0, limit_q};
    flr_w = {14'b0, floor_q};
    c1    = (c_mag > lim_w) ? lim_w : c_mag;
    if (c1 != '0 && c1 < flr_w) begin
      c2 = (flr_w > lim_w) ? lim_w : flr_w;
    end else begin
      c2 = c1;
    end
    cmd_calc = p_q[39] ? ANG_W'(-$signed({1'b0, c2})) : ANG_W'(c2);
    yaw_go   = !in_band && (cmd_calc != '0) && (axle_q != '0) && (speed_q != '0);

    spd_abs = speed_q[15] ? 16'(-speed_q) : speed_q;
    den_raw = 33'(axle_q) * 33'(cres_q.x_q16);
    num_raw = 53'(ys_q) * 53'(dt_q);

    if (!neg_q) begin
      yaw_sat = (quo > NUM_W'(ANG_MAX)) ? ANG_MAX : quo[ANG_W-1:0];
    end else begin
      yaw_sat = (quo > NUM_W'(24'h800000)) ? ANG_MIN : ANG_W'(-quo[ANG_W-1:0]);
    end

    yaw_abs   = abs_ang(yaw_q);
    rem_abs_u = abs_ang(rem_q);
    if ((rem_q > 0 && yaw_q > 0) || (rem_q < 0 && yaw_q < 0)) begin
      rem_new = (yaw_abs >= rem_abs_u) ? '0 : rem_q - yaw_q;
    end else if (rem_abs_u <= {8'b0, band_q}) begin
      rem_new = '0;
    end else begin
      rem_new = rem_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      speed_q      <= hcsc_pkg::RST_SPEED;
      gain_q       <= hcsc_pkg::RST_GAIN;
      axle_q       <= hcsc_pkg::RST_AXLE;
      limit_q      <= hcsc_pkg::RST_LIMIT;
      floor_q      <= hcsc_pkg::RST_FLOOR;
      band_q       <= hcsc_pkg::RST_BAND;
      rem_q        <= '0;
      turn_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      cord_start_q <= 1'b0;
      div_start_q  <= 1'b0;
    end else begin
      cord_start_q <= 1'b0;
      div_start_q  <= 1'b0;
      // drop the word once taken, unless a new one is loaded this cycle
      if (out_valid_q && !out_stall_i && state_q != ST_UPD) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_wr) begin
        unique case (cfg_idx)
          hcsc_pkg::REG_SPEED: speed_q <= pwdata[15:0];
          hcsc_pkg::REG_GAIN:  gain_q  <= pwdata[15:0];
          hcsc_pkg::REG_AXLE:  axle_q  <= pwdata[15:0];
          hcsc_pkg::REG_LIMIT: limit_q <= pwdata[16:0];
          hcsc_pkg::REG_FLOOR: floor_q <= pwdata[16:0];
          hcsc_pkg::REG_BAND:  band_q  <= pwdata[15:0];
          default: ;
        endcase
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            if (operation_i == hcsc_pkg::OP_REQUEST) begin
              rem_q <= req_sat;
              if (req_abs > {8'b0, band_q}) begin
                turn_q <= 1'b1;
              end
            end else if (elapsed_time_i != '0) begin
              dt_q    <= elapsed_time_i;
              state_q <= ST_MUL;
            end
          end
        end
        ST_MUL: begin
          p_q     <= 40'($signed(gain_q)) * 40'(rem_q);
          state_q <= ST_CMD;
        end
        ST_CMD: begin
          yaw_q <= '0;
          if (in_band) begin
            cmd_q  <= '0;
            rem_q  <= '0;
            turn_q <= 1'b0;
          end else begin
            cmd_q  <= cmd_calc;
            turn_q <= 1'b1;
          end
          if (yaw_go) begin
            cord_start_q <= 1'b1;
            state_q      <= ST_CORD;
          end else begin
            state_q <= ST_UPD;
          end
        end
        ST_CORD: begin
          if (cord_done) begin
            cres_q  <= cord_res;
            state_q <= ST_MUL1;
          end
        end
        ST_MUL1: begin
          ys_q    <= 33'(cres_q.y_mag) * 33'(spd_abs);
          den_q   <= DEN_W'(den_raw) << DEN_SHIFT;
          neg_q   <= cmd_q[ANG_W-1] ^ cres_q.y_neg ^ speed_q[15];
          state_q <= ST_MUL2;
        end
        ST_MUL2: begin
          num_q       <= NUM_W'(num_raw) << NUM_SHIFT;
          div_start_q <= 1'b1;
          state_q     <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            yaw_q   <= yaw_sat;
            state_q <= ST_UPD;
          end
        end
        ST_UPD: begin
          // hold until the output register is free
          if (!out_valid_q || !out_stall_i) begin
            rem_q       <= rem_new;
            out_steer_q <= cmd_q;
            out_speed_q <= speed_q;
            out_turn_q  <= turn_q;
            out_head_q  <= rem_new;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign cmd_abs = abs_ang(cmd_q);

  hcsc_cordic #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cord_start_q),
    .mag_i  (cmd_abs[hcsc_pkg::MAG_W-1:0]),
    .done_o (cord_done),
    .res_o  (cord_res)
  );

  hcsc_div #(
    .NUM_W(NUM_W),
    .DEN_W(DEN_W)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start_q),
    .num_i  (num_q),
    .den_i  (den_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  assign in_stall_o       = (state_q != ST_IDLE);
  assign out_valid_o      = out_valid_q;
  assign steering_angle_o = out_steer_q;
  assign speed_out_o      = out_speed_q;
  assign turning_o        = out_turn_q;
  assign heading_left_o   = out_head_q;
  assign steer_mag        = abs_ang(out_steer_q);

  a_steer_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> steer_mag <= {7'b0, limit_q})
    else $error("steering word exceeds limit");

  a_straight_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !turning_o) |-> (steering_angle_o == '0 && heading_left_o == '0))
    else $error("straight word carries steering or heading");

  a_cord_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cord_done |-> state_q == ST_CORD)
    else $error("CORDIC finished outside its wait state");

  a_div_only_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> state_q == ST_DIV)
    else $error("divider finished outside its wait state");

endmodule

@@ dv/heading_change_steering_controller_test.sv @@
// ----------------------------------------------------------------------------
// heading_change_steering_controller_test
// Drives heading change requests and control ticks through the valid/stall
// channels, reprograms the registers over APB between phases, and checks
// every steering word against a cycle-free predictor of the controller or a typed word.
// ----------------------------------------------------------------------------
module heading_change_steering_controller_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [23:0] steer;
    logic signed [15:0] speed;
    logic               turn;
    logic signed [23:0] left;
  } steer_word_t;

  typedef struct {
    bit                 op;
    int                 delta;
    int                 dt;
    bit                 typed;
    steer_word_t        word;
  } stim_row_t;

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, operation_i;
  logic signed [23:0] heading_delta_i;
  logic [19:0] elapsed_time_i;
  logic out_valid_o, out_stall_i;
  logic signed [23:0] steering_angle_o, heading_left_o;
  logic signed [15:0] speed_out_o;
  logic turning_o;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  heading_change_steering_controller uut (.*);

  // predictor state and register copies
  longint hdg_left;
  bit     turn_flag;
  longint c_speed, c_gain, c_axle, c_limit, c_floor, c_band;

  steer_word_t expected_words[$];
  bit          row_typed;
  steer_word_t row_word;
  int          mismatches;
  bit          idle_on;
  bit          hold_req;

  longint atan_tbl [30] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143,
    131071, 65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255,
    127, 63, 31, 15, 8, 4, 2};

  function automatic longint absl(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clip_angle(longint v);
    if (v > 8388607) return 8388607;
    if (v < -8388608) return -8388608;
    return v;
  endfunction

  // bicycle-model yaw over one tick, angle units
  function automatic longint yaw_turned(longint cmd, longint dt);
    longint a, q, z, x, y, dx, dy, num, den, res;
    bit neg;
    a = absl(cmd) <<< (30 - hcsc_pkg::ANGLE_FRAC_BITS);
    q = (a + 64'sd1686629713) / 64'sd3373259426;
    z = a - q * 64'sd3373259426;
    x = 64'sd1 <<< 30;
    y = 0;
    for (int i = 0; i < 30; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_tbl[i];
      end else begin
        x += dx; y -= dy; z += atan_tbl[i];
      end
    end
    y = y >>> 14;
    x = x >>> 14;
    if (x < 1) x = 1;
    neg = ((cmd < 0) != (y < 0)) != (c_speed < 0);
    num = absl(y) * absl(c_speed) * dt;
    den = c_axle * x;
    if (hcsc_pkg::ANGLE_FRAC_BITS >= 16) num = num <<< (hcsc_pkg::ANGLE_FRAC_BITS - 16);
    else den = den <<< (16 - hcsc_pkg::ANGLE_FRAC_BITS);
    res = num / den;
    return clip_angle(neg ? -res : res);
  endfunction

  // advance the heading state for one word; returns 1 when a steering word results
  function automatic bit steer_step(bit op, longint delta, longint dt, output steer_word_t w);
    longint cmd, yaw;
    cmd = 0;
    yaw = 0;
    w = '{default: '0};
    if (op == hcsc_pkg::OP_REQUEST) begin
      hdg_left = clip_angle(hdg_left + delta);
      if (absl(hdg_left) > c_band) turn_flag = 1;
      return 0;
    end
    if (dt == 0) return 0;
    if (absl(hdg_left) > c_band) begin
      cmd = (c_gain * hdg_left) / 256;
      turn_flag = 1;
      if (cmd > c_limit) cmd = c_limit;
      if (cmd < -c_limit) cmd = -c_limit;
      if (cmd != 0 && absl(cmd) < c_floor) begin
        cmd = cmd < 0 ? -c_floor : c_floor;
        if (cmd > c_limit) cmd = c_limit;
        if (cmd < -c_limit) cmd = -c_limit;
      end
    end else begin
      hdg_left = 0;
      turn_flag = 0;
    end
    if (c_axle != 0 && c_speed != 0 && cmd != 0) yaw = yaw_turned(cmd, dt);
    if ((hdg_left > 0 && yaw > 0) || (hdg_left < 0 && yaw < 0)) begin
      if (absl(yaw) >= absl(hdg_left)) hdg_left = 0;
      else hdg_left -= yaw;
    end else if (absl(hdg_left) <= c_band) begin
      hdg_left = 0;
    end
    w.steer = cmd[23:0];
    w.speed = c_speed[15:0];
    w.turn  = turn_flag;
    w.left  = hdg_left[23:0];
    return 1;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("FAIL heading_change_steering_controller");
    $finish;
  end

  // monitor both channels at the clock edge
  always @(posedge clk_i) begin
    steer_word_t w, e;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        if (steer_step(operation_i, longint'(heading_delta_i), longint'(elapsed_time_i), w))
          expected_words.push_back(row_typed ? row_word : w);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_words.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected steering word %0d", steering_angle_o);
        end else begin
          e = expected_words.pop_front();
          if (steering_angle_o !== e.steer || speed_out_o !== e.speed ||
              turning_o !== e.turn || heading_left_o !== e.left) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp steer %0d speed %0d turn %0b left %0d, got %0d %0d %0b %0d",
                       e.steer, e.speed, e.turn, e.left,
                       steering_angle_o, speed_out_o, turning_o, heading_left_o);
          end
        end
      end
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    out_stall_i = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(posedge clk_i);
        hold_req = 0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 10);
        out_stall_i <= 1'b1;
        repeat (n - 1) @(posedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic apb_write(hcsc_pkg::reg_idx_e idx, longint val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= 5'(int'(idx) * 4);
    pwdata  <= val[31:0];
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    case (idx)
      hcsc_pkg::REG_SPEED: c_speed = longint'($signed(val[15:0]));
      hcsc_pkg::REG_GAIN:  c_gain  = longint'($signed(val[15:0]));
      hcsc_pkg::REG_AXLE:  c_axle  = val & 64'hFFFF;
      hcsc_pkg::REG_LIMIT: c_limit = val & 64'h1FFFF;
      hcsc_pkg::REG_FLOOR: c_floor = val & 64'h1FFFF;
      hcsc_pkg::REG_BAND:  c_band  = val & 64'hFFFF;
      default: ;
    endcase
  endtask

  task automatic drain;
    wait (expected_words.size() == 0);
    // a request or a zero-time tick may still be inside the block
    repeat (120) @(posedge clk_i);
  endtask

  task automatic program_regs(longint spd, longint gain, longint axle, longint lim,
                              longint flr, longint band);
    drain();
    apb_write(hcsc_pkg::REG_SPEED, spd);
    apb_write(hcsc_pkg::REG_GAIN, gain);
    apb_write(hcsc_pkg::REG_AXLE, axle);
    apb_write(hcsc_pkg::REG_LIMIT, lim);
    apb_write(hcsc_pkg::REG_FLOOR, flr);
    apb_write(hcsc_pkg::REG_BAND, band);
  endtask

  // offer one word and hold it until accepted, then maybe idle
  task automatic send_word(bit op, int delta, int dt);
    int n;
    in_valid_i      <= 1'b1;
    operation_i     <= op;
    heading_delta_i <= delta[23:0];
    elapsed_time_i  <= dt[19:0];
    do @(posedge clk_i); while (in_stall_o);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 10);
      in_valid_i <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
  endtask

  task automatic random_word;
    int r, delta, dt;
    r = $urandom_range(0, 99);
    if (r < 40) begin
      r = $urandom_range(0, 9);
      if (r < 7) delta = $urandom_range(0, 400000) - 200000;
      else if (r < 8) delta = int'($urandom());
      else delta = $urandom_range(0, 4000) - 2000;
      send_word(hcsc_pkg::OP_REQUEST, delta, int'($urandom()));
    end else begin
      r = $urandom_range(0, 19);
      if (r == 0) dt = 0;
      else if (r < 3) dt = int'($urandom());
      else dt = $urandom_range(1, 13107);
      send_word(hcsc_pkg::OP_TICK, int'($urandom()), dt);
    end
  endtask

  stim_row_t rows[$];

  initial begin
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = hcsc_pkg::OP_REQUEST;
    heading_delta_i = '0;
    elapsed_time_i = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    mismatches = 0;
    row_typed = 0;
    hold_req = 0;
    idle_on = 1;
    hdg_left = 0;
    turn_flag = 0;
    c_speed = 384; c_gain = 512; c_axle = 435;
    c_limit = 28595; c_floor = 1144; c_band = 572;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset state, zero time, saturation both ways, extreme times
    rows = '{
      '{hcsc_pkg::OP_TICK,    0,        1,       1, '{24'sd0, 16'sd384, 1'b0, 24'sd0}},
      '{hcsc_pkg::OP_TICK,    0,        0,       0, '{default: '0}},
      '{hcsc_pkg::OP_REQUEST, 8388607,  0,       0, '{default: '0}},
      '{hcsc_pkg::OP_REQUEST, 8388607,  0,       0, '{default: '0}},
      '{hcsc_pkg::OP_TICK,    0,        1048575, 0, '{default: '0}},
      '{hcsc_pkg::OP_TICK,    -1,       1,       0, '{default: '0}},
      '{hcsc_pkg::OP_REQUEST, -8388608, 0,       0, '{default: '0}},
      '{hcsc_pkg::OP_REQUEST, -8388608, 0,       0, '{default: '0}},
      '{hcsc_pkg::OP_TICK,    0,        1048575, 0, '{default: '0}},
      '{hcsc_pkg::OP_TICK,    0,        6554,    0, '{default: '0}},
      '{hcsc_pkg::OP_REQUEST, 573,      0,       0, '{default: '0}},
      '{hcsc_pkg::OP_TICK,    0,        6554,    0, '{default: '0}},
      '{hcsc_pkg::OP_REQUEST, -600,     0,       0, '{default: '0}},
      '{hcsc_pkg::OP_TICK,    0,        65536,   0, '{default: '0}},
      '{hcsc_pkg::OP_REQUEST, 572,      0,       0, '{default: '0}},
      '{hcsc_pkg::OP_TICK,    0,        1,       0, '{default: '0}},
      '{hcsc_pkg::OP_REQUEST, 3000000,  0,       0, '{default: '0}},
      '{hcsc_pkg::OP_TICK,    0,        1048575, 0, '{default: '0}},
      '{hcsc_pkg::OP_TICK,    0,        1048575, 0, '{default: '0}}
    };
    foreach (rows[i]) begin
      // update after the monitor has sampled the accepting edge
      row_typed <= rows[i].typed;
      row_word  <= rows[i].word;
      send_word(rows[i].op, rows[i].delta, rows[i].dt);
    end
    in_valid_i <= 1'b0;
    row_typed  <= 0;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: program_regs(384, 512, 435, 28595, 1144, 572);
        1: program_regs(32767, 32767, 65535, 131071, 131071, 65535);
        2: program_regs(-32768, -32768, 0, 0, 0, 0);
        3: program_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(1, 65535), $urandom_range(0, 131071),
                        $urandom_range(0, 131071), $urandom_range(0, 65535));
        4: program_regs($urandom_range(0, 65535), $urandom_range(1, 64),
                        $urandom_range(1, 64), $urandom_range(20000, 78643),
                        $urandom_range(500, 30000), $urandom_range(0, 2000));
        default: begin
          program_regs(-384, 512, 435, 28595, 1144, 572);
          idle_on = 0;
        end
      endcase
      for (int k = 0; k < 170; k++) begin
        if (ph == 3 && k == 20) hold_req = 1;
        random_word();
      end
      in_valid_i <= 1'b0;
    end

    wait (expected_words.size() == 0);
    repeat (120) @(posedge clk_i);
    if (mismatches == 0 && expected_words.size() == 0)
      $display("PASS heading_change_steering_controller");
    else
      $display("FAIL heading_change_steering_controller");
    $finish;
  end

endmodule
